// File: rtl/tsmf_pkg.sv
// ----------------------------------------------------------------------------
// tsmf_pkg: shared constants for the threshold spike median filter
// Sample width, default window length and reset threshold (1.0 in Q16.16).
// ----------------------------------------------------------------------------
package tsmf_pkg;

	// signed Q16.16 sample width
	localparam int SAMPLE_W = 32;

	// default median window; history keeps WINDOW/2 past outputs
	localparam int DEFAULT_WINDOW = 4;

	// threshold after reset: 1.0 in Q16.16
	localparam logic signed [SAMPLE_W-1:0] THRESH_RESET = 32'sh0001_0000;

endpackage

// File: rtl/tsmf_median.sv
// ----------------------------------------------------------------------------
// tsmf_median: median of the valid history entries plus the new sample
// Rank-based selection: every value is ranked by parallel compares, then the
// two middle ranks are picked and averaged with an arithmetic shift.
// ----------------------------------------------------------------------------
module tsmf_median #(
	parameter int HIST_DEPTH = tsmf_pkg::DEFAULT_WINDOW / 2,
	localparam int FW = $clog2(HIST_DEPTH + 1)
) (
	input  logic [HIST_DEPTH-1:0][tsmf_pkg::SAMPLE_W-1:0] hist,
	input  logic [FW-1:0]                                 fill,
	input  logic signed [tsmf_pkg::SAMPLE_W-1:0]          sample,
	output logic signed [tsmf_pkg::SAMPLE_W-1:0]          median
);
	import tsmf_pkg::*;

	localparam int NV = HIST_DEPTH + 1;

	logic signed [SAMPLE_W-1:0] vals [NV];
	logic [NV-1:0]              live;
	logic [FW-1:0]              rank [NV];
	logic [FW:0]                n_vals;
	logic [FW-1:0]              lo_rank;
	logic [FW-1:0]              hi_rank;
	logic [SAMPLE_W-1:0]        lo_val;
	logic [SAMPLE_W-1:0]        hi_val;
	logic signed [SAMPLE_W:0]   pair_sum;

	// gather candidates; history entries count only below the fill level
	always_comb begin
		for (int i = 0; i < HIST_DEPTH; i++) begin
			vals[i] = hist[i];
			live[i] = (FW'(i) < fill);
		end
		vals[HIST_DEPTH] = sample;
		live[HIST_DEPTH] = 1'b1;
	end

	// rank of each value among live values, ties broken by position
	always_comb begin
		for (int i = 0; i < NV; i++) begin
			rank[i] = '0;
			for (int j = 0; j < NV; j++) begin
				if (j != i && live[j] &&
				    ((vals[j] < vals[i]) || (vals[j] == vals[i] && j < i))) begin
					rank[i] = rank[i] + FW'(1);
				end
			end
		end
	end

	// middle ranks: equal for an odd count, adjacent for an even count
	assign n_vals  = {1'b0, fill} + {{FW{1'b0}}, 1'b1};
	assign lo_rank = fill >> 1;
	assign hi_rank = n_vals[FW:1];

	// one-hot pick of the two middle values
	always_comb begin
		lo_val = '0;
		hi_val = '0;
		for (int i = 0; i < NV; i++) begin
			if (live[i] && rank[i] == lo_rank) begin
				lo_val = lo_val | vals[i];
			end
			if (live[i] && rank[i] == hi_rank) begin
				hi_val = hi_val | vals[i];
			end
		end
	end

	// average at full width, floor by arithmetic shift
	assign pair_sum = $signed({lo_val[SAMPLE_W-1], lo_val}) +
	                  $signed({hi_val[SAMPLE_W-1], hi_val});
	assign median   = pair_sum[SAMPLE_W:1];

endmodule

// File: rtl/threshold_spike_median_filter.sv
// ----------------------------------------------------------------------------
// threshold_spike_median_filter: conditional median spike filter, Q16.16
// Samples above spike_threshold are replaced by a short-window median.
// ----------------------------------------------------------------------------
// Usage:
//   Sample channel: sample_valid / sample_stall carry one signed Q16.16
//   sample per beat. Result channel: result_valid / result_stall carry
//   filtered and replaced, exactly one result beat per sample beat.
//   Config channel: cfg_valid / cfg_ready write spike_threshold; cfg_ready
//   is always high, write only while no sample is in flight.
//   An accepted sample passes the input register, then the result register,
//   to the result port. Throughput: one sample per cycle unless stalled.
//   The median of up to WINDOW/2 past outputs plus the sample is formed by
//   parallel compares, combinationally between the input register and
//   the result register; the history feedback closes in the same cycle.
//   Reset: threshold returns to 1.0, history is empty, no result is valid.
//   When the receiver stalls the result register holds, the input register
//   still fills once, then sample_stall rises until the result is taken.
// ----------------------------------------------------------------------------
module threshold_spike_median_filter #(
	parameter int WINDOW = tsmf_pkg::DEFAULT_WINDOW
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration write
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic signed [tsmf_pkg::SAMPLE_W-1:0] spike_threshold,
	// sample channel
	input  logic                                sample_valid,
	output logic                                sample_stall,
	input  logic signed [tsmf_pkg::SAMPLE_W-1:0] sample,
	// result channel
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic signed [tsmf_pkg::SAMPLE_W-1:0] filtered,
	output logic                                replaced
);
	import tsmf_pkg::*;

	localparam int HIST_DEPTH = WINDOW / 2;
	localparam int FW         = $clog2(HIST_DEPTH + 1);
	localparam int SLW        = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

	logic signed [SAMPLE_W-1:0]              thresh_q;
	logic                                    valid_s1;
	logic signed [SAMPLE_W-1:0]              sample_s1;
	logic [HIST_DEPTH-1:0][SAMPLE_W-1:0]     hist_q;
	logic [FW-1:0]                           fill_q;
	logic [SLW-1:0]                          slot_q;
	logic                                    result_valid_q;
	logic signed [SAMPLE_W-1:0]              filtered_q;
	logic                                    replaced_q;

	logic                                    advance;
	logic                                    load_s1;
	logic                                    spike;
	logic signed [SAMPLE_W-1:0]              median;
	logic signed [SAMPLE_W-1:0]              result_next;

	// handshake: stage 1 moves on when the result register is free or taken
	assign cfg_ready    = 1'b1;
	assign advance      = !result_valid_q || !result_stall;
	assign sample_stall = valid_s1 && !advance;
	assign load_s1      = sample_valid && !sample_stall;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thresh_q <= spike_threshold;
		end
	end

	// spike test and median
	assign spike = sample_s1 > thresh_q;

	tsmf_median #(
		.HIST_DEPTH (HIST_DEPTH)
	) u_median (
		.hist   (hist_q),
		.fill   (fill_q),
		.sample (sample_s1),
		.median (median)
	);

	assign result_next = spike ? median : sample_s1;

	// control state: stage valids, history fill and ring slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
			fill_q         <= '0;
			slot_q         <= '0;
		end else begin
			if (!sample_stall) begin
				valid_s1 <= sample_valid;
			end
			if (advance) begin
				result_valid_q <= valid_s1;
			end
			if (valid_s1 && advance) begin
				if (fill_q < FW'(HIST_DEPTH)) begin
					fill_q <= fill_q + FW'(1);
				end
				if (slot_q == SLW'(HIST_DEPTH - 1)) begin
					slot_q <= '0;
				end else begin
					slot_q <= slot_q + SLW'(1);
				end
			end
		end
	end

	// payload: input register, history ring and result register
	always_ff @(posedge clk) begin
		if (load_s1) begin
			sample_s1 <= sample;
		end
		if (valid_s1 && advance) begin
			hist_q[slot_q] <= result_next;
			filtered_q     <= result_next;
			replaced_q     <= spike;
		end
	end

	assign result_valid = result_valid_q;
	assign filtered     = filtered_q;
	assign replaced     = replaced_q;

`ifndef SYNTHESIS
	// fill level never passes the history depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(HIST_DEPTH))
		else $error("history fill above depth");

	// ring slot stays inside the history
	a_slot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLW'(HIST_DEPTH - 1))
		else $error("history slot out of range");

	// a stage 1 item that moves on always yields a result beat
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance) |=> result_valid)
		else $error("result beat lost");

	// a sample at or below the threshold passes unchanged
	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && !spike) |=>
			(filtered == $past(sample_s1) && !replaced))
		else $error("non-spike sample altered");
`endif

endmodule

// File: dv/tsmf_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tsmf_checker: result predictor and scoreboard for the spike median filter
// Watches the config, sample and result channels, keeps its own copy of the
// threshold and history, predicts one result per sample beat and compares
// each result beat field by field against the oldest pending prediction.
// ----------------------------------------------------------------------------
module tsmf_checker (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_valid,
	input  logic                                 cfg_ready,
	input  logic signed [tsmf_pkg::SAMPLE_W-1:0] spike_threshold,
	input  logic                                 sample_valid,
	input  logic                                 sample_stall,
	input  logic signed [tsmf_pkg::SAMPLE_W-1:0] sample,
	input  logic                                 result_valid,
	input  logic                                 result_stall,
	input  logic signed [tsmf_pkg::SAMPLE_W-1:0] filtered,
	input  logic                                 replaced,
	output int                                   mismatches,
	output int                                   outstanding
);
	import tsmf_pkg::*;

	// history keeps half a window of past outputs
	localparam int HIST_DEPTH = DEFAULT_WINDOW / 2;
	// the block holds at most two beats, so a few slots are plenty
	localparam int PEND_DEPTH = 8;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] filtered;
		logic                       replaced;
	} filter_out_t;

	filter_out_t                pending_results [PEND_DEPTH];
	int                         pend_wr = 0;
	int                         pend_rd = 0;
	int                         pend_count = 0;
	logic signed [SAMPLE_W-1:0] thresh_copy = THRESH_RESET;
	logic signed [SAMPLE_W-1:0] past_out [HIST_DEPTH];
	int                         past_count = 0;
	int                         next_slot = 0;

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $time, what);
		mismatches++;
	endtask

	// one sample in, one result out; history takes what was output
	function automatic filter_out_t filter_sample(input logic signed [SAMPLE_W-1:0] s);
		longint      vals [HIST_DEPTH+1];
		longint      key;
		longint      sum;
		int          n;
		int          j;
		filter_out_t r;
		r.filtered = s;
		r.replaced = 1'b0;
		if (s > thresh_copy) begin
			n = 0;
			for (int k = 0; k < past_count; k++) begin
				vals[n] = past_out[k];
				n++;
			end
			vals[n] = s;
			n++;
			// insertion sort, at most three values
			for (int i = 1; i < n; i++) begin
				key = vals[i];
				j = i;
				while (j > 0 && vals[j-1] > key) begin
					vals[j] = vals[j-1];
					j--;
				end
				vals[j] = key;
			end
			// even count: mean of middle pair, rounded toward minus infinity
			if (n % 2 == 0) begin
				sum = vals[n/2-1] + vals[n/2];
				r.filtered = 32'(sum >>> 1);
			end else begin
				r.filtered = 32'(vals[n/2]);
			end
			r.replaced = 1'b1;
		end
		past_out[next_slot] = r.filtered;
		next_slot = (next_slot + 1 >= HIST_DEPTH) ? 0 : next_slot + 1;
		if (past_count < HIST_DEPTH)
			past_count++;
		return r;
	endfunction

	// predict on sample beats, compare on result beats, track threshold writes
	always @(posedge clk or negedge arst_n) begin
		filter_out_t want;
		if (!arst_n) begin
			pend_wr = 0;
			pend_rd = 0;
			pend_count = 0;
			thresh_copy = THRESH_RESET;
			for (int k = 0; k < HIST_DEPTH; k++)
				past_out[k] = '0;
			past_count = 0;
			next_slot = 0;
			outstanding <= 0;
		end else begin
			if (sample_valid && !sample_stall) begin
				if (pend_count == PEND_DEPTH) begin
					report_mismatch("too many sample beats without a result");
				end else begin
					pending_results[pend_wr] = filter_sample(sample);
					pend_wr = (pend_wr + 1) % PEND_DEPTH;
					pend_count++;
				end
			end
			if (result_valid && !result_stall) begin
				if (pend_count == 0) begin
					report_mismatch($sformatf("result beat with none pending: filtered %h replaced %b",
						filtered, replaced));
				end else begin
					want = pending_results[pend_rd];
					pend_rd = (pend_rd + 1) % PEND_DEPTH;
					pend_count--;
					if (filtered !== want.filtered)
						report_mismatch($sformatf("filtered %h, predicted %h",
							filtered, want.filtered));
					if (replaced !== want.replaced)
						report_mismatch($sformatf("replaced %b, predicted %b",
							replaced, want.replaced));
				end
			end
			if (cfg_valid && cfg_ready)
				thresh_copy = spike_threshold;
			outstanding <= pend_count;
		end
	end

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for threshold_spike_median_filter
// Drives directed and random sample beats under several thresholds, with
// random idling on both channels and long receiver hold-offs; the checker
// predicts and compares, this module only stimulates and gives the verdict.
// ----------------------------------------------------------------------------
module tb;
	import tsmf_pkg::*;

	localparam logic signed [SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_LEN    = 48;
	localparam int DRAIN_WAIT  = 8;

	logic                       clk = 1'b0;
	logic                       arst_n = 1'b0;
	logic                       cfg_valid = 1'b0;
	logic                       cfg_ready;
	logic signed [SAMPLE_W-1:0] spike_threshold = THRESH_RESET;
	logic                       sample_valid = 1'b0;
	logic                       sample_stall;
	logic signed [SAMPLE_W-1:0] sample = '0;
	logic                       result_valid;
	logic                       result_stall = 1'b0;
	logic signed [SAMPLE_W-1:0] filtered;
	logic                       replaced;
	int                         mismatches;
	int                         outstanding;
	bit                         idle_on = 1'b1;
	int                         hold_len = 0;
	int                         quiet_cycles = 0;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	threshold_spike_median_filter u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.spike_threshold (spike_threshold),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.sample          (sample),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.filtered        (filtered),
		.replaced        (replaced)
	);

	tsmf_checker u_chk (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.spike_threshold (spike_threshold),
		.sample_valid    (sample_valid),
		.sample_stall    (sample_stall),
		.sample          (sample),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.filtered        (filtered),
		.replaced        (replaced),
		.mismatches      (mismatches),
		.outstanding     (outstanding)
	);

	// result side: random stalls, or a long hold-off when requested
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_len > 0) begin
				hold_left = hold_len;
				hold_len = 0;
			end
			if (hold_left > 0) begin
				result_stall <= 1'b1;
				hold_left--;
			end else begin
				result_stall <= idle_on && ($urandom_range(99) < 24);
			end
		end
	end

	// watchdog on cycles with no beat on any channel
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && !sample_stall) || (result_valid && !result_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("status: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// one sample beat, with random idle cycles ahead of it
	task automatic push_sample(input logic signed [SAMPLE_W-1:0] v);
		while (idle_on && $urandom_range(99) < 24) begin
			@(negedge clk);
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		@(negedge clk);
		sample_valid <= 1'b1;
		sample <= v;
		do @(posedge clk); while (sample_stall);
	endtask

	// stop offering, let every pending result out, then cover the pipeline
	task automatic drain;
		@(negedge clk);
		sample_valid <= 1'b0;
		while (outstanding != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic set_threshold(input logic signed [SAMPLE_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		spike_threshold <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// mostly near the threshold or small values, some extremes and raw noise
	function automatic logic signed [SAMPLE_W-1:0] pick_sample(
		input logic signed [SAMPLE_W-1:0] th
	);
		logic signed [SAMPLE_W-1:0] v;
		case ($urandom_range(9))
			0: v = $urandom;
			1: begin
				case ($urandom_range(3))
					0: v = S_MAX;
					1: v = S_MIN;
					2: v = '0;
					default: v = -1;
				endcase
			end
			2, 3, 4, 5: v = th + $signed($urandom_range(131072)) - 32'sd65536;
			default: v = $signed($urandom_range(1 << 20)) - 32'sd524288;
		endcase
		return v;
	endfunction

	task automatic run_phase(
		input logic signed [SAMPLE_W-1:0] th,
		input int                         count,
		input bit                         quiet,
		input bit                         squeeze
	);
		set_threshold(th);
		idle_on = !quiet;
		for (int i = 0; i < count; i++) begin
			if (squeeze && i == count / 3)
				hold_len = HOLD_LEN;
			push_sample(pick_sample(th));
		end
		idle_on = 1'b1;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset threshold 1.0: spike on empty history, then partial and full
		push_sample(S_MAX);
		push_sample(32'sh0005_0000);
		push_sample(S_MIN);
		push_sample(-32'sd1);
		push_sample(32'sh0001_0000);
		push_sample(32'sh0001_0001);
		push_sample(S_MAX);
		push_sample(S_MAX);
		push_sample(32'sh0000_0000);
		push_sample(32'sh0003_0000);
		push_sample(32'sh0002_0000);

		// lowest threshold: everything but the minimum is a spike
		set_threshold(S_MIN);
		push_sample(S_MIN);
		push_sample(S_MIN + 32'sd1);
		push_sample(S_MAX);
		push_sample(32'shFFFF_0000);

		// highest threshold: nothing is a spike
		set_threshold(S_MAX);
		push_sample(S_MAX);
		push_sample(S_MIN);
		push_sample(32'sh1234_5678);

		// zero threshold, alternating bit patterns
		set_threshold('0);
		push_sample(32'sh0000_0000);
		push_sample(32'sh0000_0001);
		push_sample(32'sh5555_5555);
		push_sample(32'shAAAA_AAAA);
		push_sample(S_MAX);

		// random phases
		run_phase(THRESH_RESET, 80, 1'b1, 1'b1);
		run_phase($urandom, 80, 1'b0, 1'b0);
		run_phase(S_MIN, 60, 1'b0, 1'b1);
		run_phase(S_MAX, 40, 1'b0, 1'b0);
		run_phase('0, 80, 1'b0, 1'b0);
		run_phase($signed($urandom_range(1 << 21)) - 32'sh0010_0000, 80, 1'b0, 1'b1);
		run_phase($urandom, 80, 1'b0, 1'b0);

		drain();
		if (mismatches == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// File: filelist.f
rtl/tsmf_pkg.sv
rtl/tsmf_median.sv
rtl/threshold_spike_median_filter.sv
dv/tsmf_checker.sv
dv/tb.sv
